### rtl/core/cts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, constants and the half-precision to Q2.16 conversion for the
// cosine top-k search core.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int CTS_MAX_RECORDS = 1024;
    localparam int CTS_MAX_DIM     = 1024;
    localparam int CTS_MAX_K       = 64;

    localparam int QUOT_W = 31;
    localparam logic [QUOT_W-1:0] SCORE_ONE = 31'h4000_0000;

    typedef enum logic [1:0] {
        OP_REC_ELEM   = 2'd0,
        OP_REC_NORM   = 2'd1,
        OP_QUERY_ELEM = 2'd2,
        OP_SEARCH     = 2'd3
    } cts_op_t;

    typedef enum logic [1:0] {
        CFG_DIM_IN_USE   = 2'd0,
        CFG_RECORD_COUNT = 2'd1,
        CFG_TOP_K        = 2'd2
    } cts_cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_NORM_CHK,
        S_DOT,
        S_DRAIN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } cts_state_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } cts_list_ctrl_t;

    // Convert a half-precision pattern to signed Q2.16, round half away
    // from zero, saturate; NaN gives zero
    function automatic logic signed [17:0] half_to_q(input logic [15:0] h);
        logic              s;
        logic [4:0]        e;
        logic [9:0]        m;
        logic [10:0]       mant;
        logic [32:0]       mag;
        logic [3:0]        sh;
        logic signed [17:0] q;
        s    = h[15];
        e    = h[14:10];
        m    = h[9:0];
        mant = {1'b1, m};
        mag  = '0;
        sh   = '0;
        q    = '0;
        if (e == 5'd31) begin
            if (m != 10'd0)
                q = '0;
            else
                q = s ? 18'sh20000 : 18'sh1FFFF;
        end
        else begin
            if (e == 5'd0)
                mag = 33'((11'(m) + 11'd128) >> 8);
            else if (e >= 5'd9)
                mag = 33'(mant) << (e - 5'd9);
            else
            begin
                sh  = 4'(5'd9 - e);
                mag = (33'(mant) + (33'd1 << (sh - 4'd1))) >> sh;
            end
            if (s) begin
                if (mag > 33'd131072)
                    mag = 33'd131072;
                q = -$signed(mag[17:0]);
            end
            else begin
                if (mag > 33'd131071)
                    mag = 33'd131071;
                q = $signed(mag[17:0]);
            end
        end
        return q;
    endfunction

endpackage

### rtl/core/cts_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_divider
// Restoring divider, one quotient bit per cycle: floor(num * 2^46 / den),
// saturated to 2^30.
// ----------------------------------------------------------------------------
module cts_divider
    import cts_pkg::*;
#(
    parameter int NUM_W = 47
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [63:0]       den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [63:0]       rem_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              sat_reg;

    logic [64:0] num_sh;
    logic        over;
    logic [64:0] rem2;
    logic [64:0] diff;
    logic        ge;

    // Quotient of 2^31 or more saturates at once; otherwise start from num<<15
    assign num_sh = 65'(num) << 15;
    assign over   = num_sh >= {1'b0, den};
    assign rem2   = {rem_reg, 1'b0};
    assign diff   = rem2 - {1'b0, den};
    assign ge     = rem2 >= {1'b0, den};

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_sh[63:0];
            q_reg   <= '0;
            sat_reg <= over;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[63:0] : rem2[63:0];
            q_reg   <= {q_reg[QUOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = (sat_reg || q_reg > SCORE_ONE) ? SCORE_ONE : q_reg;

endmodule

### rtl/core/cts_best_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_best_list
// Sorted list of the best hits: parallel insert with shift-down, pop from
// the head for output.
// ----------------------------------------------------------------------------
module cts_best_list
    import cts_pkg::*;
#(
    parameter int MAX_K = CTS_MAX_K,
    parameter int CNT_W = $clog2(MAX_K + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cts_list_ctrl_t     ctrl,
    input  logic [9:0]         ins_index,
    input  logic signed [31:0] ins_score,
    input  logic [CNT_W-1:0]   k,
    output logic [9:0]         head_index,
    output logic signed [31:0] head_score,
    output logic [CNT_W-1:0]   count
);

    logic signed [31:0] score_reg [MAX_K];
    logic [9:0]         idx_reg   [MAX_K];
    logic [CNT_W-1:0]   cnt_reg;
    logic [MAX_K-1:0]   place;

    // Mark entries that the new item takes or pushes down
    always_comb
    begin
        for (int j = 0; j < MAX_K; j++)
        begin
            if (CNT_W'(j) >= k)
                place[j] = 1'b0;
            else if (CNT_W'(j) < cnt_reg)
                place[j] = ins_score > score_reg[j];
            else
                place[j] = (CNT_W'(j) == cnt_reg);
        end
    end

    // Entry update: insert, or shift up on pop
    for (genvar j = 0; j < MAX_K; j++)
    begin : g_entry
        always_ff @(posedge clk)
        begin
            if (ctrl.insert && place[j])
            begin
                if (j == 0)
                begin
                    score_reg[j] <= ins_score;
                    idx_reg[j]   <= ins_index;
                end
                else
                begin
                    score_reg[j] <= place[(j > 0) ? j - 1 : 0] ? score_reg[(j > 0) ? j - 1 : 0]
                                                               : ins_score;
                    idx_reg[j]   <= place[(j > 0) ? j - 1 : 0] ? idx_reg[(j > 0) ? j - 1 : 0]
                                                               : ins_index;
                end
            end
            else if (ctrl.pop && j < MAX_K - 1)
            begin
                score_reg[j] <= score_reg[(j < MAX_K - 1) ? j + 1 : j];
                idx_reg[j]   <= idx_reg[(j < MAX_K - 1) ? j + 1 : j];
            end
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctrl.clear)
            cnt_reg <= '0;
        else if (ctrl.insert && cnt_reg < k)
            cnt_reg <= cnt_reg + 1'b1;
        else if (ctrl.pop && cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    assign head_index = idx_reg[0];
    assign head_score = score_reg[0];
    assign count      = cnt_reg;

endmodule

### rtl/core/cosine_top_k_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_top_k_search_core
// Embedding store with cosine top-k search.
// Input channel (in_valid/in_ready): opcode plus payload. Record element,
// record norm and query element items are written when they are accepted.
// A search item scores each record below record_count with nonzero norm:
// each record has its norm fetched and tested, and a scored record then
// sends dim elements through the single MAC on the store read port, drains
// the pipeline, starts the bit-serial divider and waits for its quotient.
// The hits then leave through the output register (out_valid/out_ready),
// one per cycle while the receiver is ready, best first, the last one
// marked by last; a search with no usable record gives a single item with
// hit_valid low. in_ready is low from the search item until its last hit
// has been loaded into the output register; a stalled receiver holds the
// output register and so holds the emission. The register port
// (cfg_write/cfg_index/cfg_data) writes at once, with no wait.
// Reset: registers return to dim_in_use 1024, record_count 0, top_k 1; the
// stores hold no defined content until written. No clearing pass is run.
// ----------------------------------------------------------------------------
module cosine_top_k_search_core
    import cts_pkg::*;
#(
    parameter int MAX_RECORDS = CTS_MAX_RECORDS,
    parameter int MAX_DIM     = CTS_MAX_DIM,
    parameter int MAX_K       = CTS_MAX_K
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [9:0]         record_index,
    input  logic [9:0]         element_index,
    input  logic [15:0]        element_bits,
    input  logic [31:0]        norm_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [9:0]         hit_index,
    output logic signed [31:0] score,
    output logic               hit_valid,
    output logic               last
);

    localparam int RI_W        = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int QI_W        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int STORE_DEPTH = MAX_RECORDS * MAX_DIM;
    localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DC_W        = $clog2(MAX_DIM + 1);
    localparam int CNT_W       = $clog2(MAX_K + 1);
    localparam int ACC_W       = 36 + DC_W;

    // Memories
    logic [15:0] store_mem [STORE_DEPTH];
    logic [31:0] norm_mem  [MAX_RECORDS];
    logic [15:0] qry_mem   [MAX_DIM];

    cts_state_t state_reg, state_next;

    logic [10:0] dim_reg;
    logic [10:0] rcount_reg;
    logic [6:0]  topk_reg;

    logic [31:0]          qnorm_reg;
    logic [DC_W-1:0]      dim_lim_reg;
    logic [10:0]          nrec_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [10:0]          r_reg;
    logic [DC_W-1:0]      d_reg;
    logic [63:0]          den_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [15:0]          store_rd_reg;
    logic [15:0]          qry_rd_reg;
    logic [31:0]          norm_rd_reg;
    logic signed [17:0]   qa_reg;
    logic signed [17:0]   qb_reg;
    logic signed [35:0]   prod_reg;
    logic                 rd_v_reg;
    logic                 b_v_reg;
    logic                 c_v_reg;

    logic               out_valid_reg;
    logic [9:0]         hit_index_reg;
    logic signed [31:0] score_reg;
    logic               hit_valid_reg;
    logic               last_reg;

    logic             in_acc;
    logic             search_go;
    logic [DC_W-1:0]  dim_lim_c;
    logic [10:0]      nrec_c;
    logic [CNT_W-1:0] k_c;
    logic             st_we;
    logic [SA_W-1:0]  st_waddr;
    logic [SA_W-1:0]  st_raddr;
    logic             out_ld;
    logic             div_start;
    logic             div_done;
    logic [QUOT_W-1:0] div_q;
    logic [ACC_W-1:0] acc_mag;
    logic             acc_neg;
    logic signed [31:0] new_score;
    cts_list_ctrl_t   list_ctrl;
    logic [9:0]       head_index;
    logic signed [31:0] head_score;
    logic [CNT_W-1:0] list_cnt;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign search_go = in_acc && (opcode == OP_SEARCH);

    // Clamp search settings
    always_comb
    begin
        int kk;
        dim_lim_c = (32'(dim_reg) > 32'(MAX_DIM)) ? DC_W'(MAX_DIM) : DC_W'(dim_reg);
        nrec_c    = (32'(rcount_reg) > 32'(MAX_RECORDS)) ? 11'(MAX_RECORDS) : rcount_reg;
        kk        = (topk_reg == 7'd0) ? 1 : int'(topk_reg);
        if (kk > MAX_K)
            kk = MAX_K;
        k_c = CNT_W'(kk);
    end

    // Store addressing
    assign st_we    = in_acc && (opcode == OP_REC_ELEM)
                      && (32'(record_index) < 32'(MAX_RECORDS))
                      && (32'(element_index) < 32'(MAX_DIM));
    assign st_waddr = SA_W'(32'(record_index) * 32'(MAX_DIM) + 32'(element_index));
    assign st_raddr = SA_W'(32'(r_reg) * 32'(MAX_DIM) + 32'(d_reg));

    // Embedding store
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= element_bits;
        store_rd_reg <= store_mem[st_raddr];
    end

    // Record norms
    always_ff @(posedge clk)
    begin
        if (in_acc && (opcode == OP_REC_NORM) && (32'(record_index) < 32'(MAX_RECORDS)))
            norm_mem[RI_W'(record_index)] <= norm_value;
        norm_rd_reg <= norm_mem[RI_W'(r_reg)];
    end

    // Query buffer
    always_ff @(posedge clk)
    begin
        if (in_acc && (opcode == OP_QUERY_ELEM) && (32'(element_index) < 32'(MAX_DIM)))
            qry_mem[QI_W'(element_index)] <= element_bits;
        qry_rd_reg <= qry_mem[QI_W'(d_reg)];
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and control
    always_comb
    begin
        state_next       = state_reg;
        out_ld           = 1'b0;
        div_start        = 1'b0;
        list_ctrl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (search_go)
                begin
                    list_ctrl.clear = 1'b1;
                    if (norm_value == 32'd0 || dim_lim_c == '0)
                        state_next = S_EMIT;
                    else
                        state_next = S_REC;
                end
            end
            S_REC:
            begin
                if (r_reg == nrec_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_NORM_CHK;
            end
            S_NORM_CHK:
            begin
                if (norm_rd_reg == 32'd0)
                    state_next = S_REC;
                else
                    state_next = S_DOT;
            end
            S_DOT:
            begin
                if (d_reg == dim_lim_reg - 1'b1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!rd_v_reg && !b_v_reg && !c_v_reg)
                    state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    list_ctrl.insert = 1'b1;
                    state_next       = S_REC;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_ld        = 1'b1;
                    list_ctrl.pop = (list_cnt != '0);
                    if (list_cnt <= CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration, pipeline valids and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg       <= 11'd1024;
            rcount_reg    <= 11'd0;
            topk_reg      <= 7'd1;
            rd_v_reg      <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DIM_IN_USE:   dim_reg    <= cfg_data;
                    CFG_RECORD_COUNT: rcount_reg <= cfg_data;
                    CFG_TOP_K:        topk_reg   <= cfg_data[6:0];
                    default:          ;
                endcase
            end
            rd_v_reg <= (state_reg == S_DOT);
            b_v_reg  <= rd_v_reg;
            c_v_reg  <= b_v_reg;
            if (out_ld)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Search datapath: counters, norm product, convert, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (search_go)
        begin
            qnorm_reg   <= norm_value;
            dim_lim_reg <= dim_lim_c;
            nrec_reg    <= nrec_c;
            k_reg       <= k_c;
            r_reg       <= '0;
        end
        if (state_reg == S_NORM_CHK)
        begin
            d_reg   <= '0;
            acc_reg <= '0;
            den_reg <= qnorm_reg * norm_rd_reg;
            if (norm_rd_reg == 32'd0)
                r_reg <= r_reg + 1'b1;
        end
        if (state_reg == S_DOT)
            d_reg <= d_reg + 1'b1;
        qa_reg   <= half_to_q(qry_rd_reg);
        qb_reg   <= half_to_q(store_rd_reg);
        prod_reg <= qa_reg * qb_reg;
        if (c_v_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (state_reg == S_DIV_WAIT && div_done)
            r_reg <= r_reg + 1'b1;
    end

    // Score magnitude and sign
    assign acc_neg   = acc_reg[ACC_W-1];
    assign acc_mag   = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign new_score = acc_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    cts_divider #(
        .NUM_W (ACC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_mag),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    cts_best_list #(
        .MAX_K (MAX_K),
        .CNT_W (CNT_W)
    ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (list_ctrl),
        .ins_index  (r_reg[9:0]),
        .ins_score  (new_score),
        .k          (k_reg),
        .head_index (head_index),
        .head_score (head_score),
        .count      (list_cnt)
    );

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            if (list_cnt == '0)
            begin
                hit_index_reg <= '0;
                score_reg     <= '0;
                hit_valid_reg <= 1'b0;
                last_reg      <= 1'b1;
            end
            else
            begin
                hit_index_reg <= head_index;
                score_reg     <= head_score;
                hit_valid_reg <= 1'b1;
                last_reg      <= (list_cnt == CNT_W'(1));
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_index = hit_index_reg;
    assign score     = score_reg;
    assign hit_valid = hit_valid_reg;
    assign last      = last_reg;

    // Divider finishes only while the sequencer waits for it
    ast_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider result outside wait state");

    // Read pipeline runs only during the dot product
    ast_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_v_reg || b_v_reg || c_v_reg) |-> (state_reg == S_DOT || state_reg == S_DRAIN))
        else $error("element pipeline busy outside dot product");

    // An empty list gives one final item without a hit
    ast_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ld && list_cnt == '0) |=> (out_valid && last && !hit_valid))
        else $error("empty search result malformed");

    // The list never holds more than k hits
    ast_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && !$past(search_go)) |-> (list_cnt <= k_reg))
        else $error("best list overfilled");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cosine top-k search core. Load and search
// items go in through a bursty valid/ready driver. A local ranking model
// predicts the hit list of every search. A monitor with a stalling receiver
// compares each hit against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import cts_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int          IDLE_LIMIT = 400000;

    typedef struct {
        cts_op_t     op;
        logic [9:0]  ri;
        logic [9:0]  ei;
        logic [15:0] bits;
        logic [31:0] norm;
    } op_item_t;

    typedef struct {
        logic [9:0]         idx;
        logic signed [31:0] scr;
        logic               hv;
        logic               lst;
    } hit_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [10:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [9:0]         record_index;
    logic [9:0]         element_index;
    logic [15:0]        element_bits;
    logic [31:0]        norm_value;
    logic               out_valid;
    logic               out_ready;
    logic [9:0]         hit_index;
    logic signed [31:0] score;
    logic               hit_valid;
    logic               last;

    // model state
    logic [15:0] vec_mem [int];
    logic [31:0] norm_mem [1024];
    logic [15:0] query_mem [1024];
    logic [10:0] m_dim;
    logic [10:0] m_nrec;
    logic [6:0]  m_topk;

    op_item_t ops_to_send [$];
    hit_t     hits_due [$];
    op_item_t cur;
    int       errors;
    int       burst_left;
    int       gap_left;
    int       stall_cnt;
    int       ready_pct;
    int       idle_cycles;
    hit_t     got;

    cosine_top_k_search_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .record_index  (record_index),
        .element_index (element_index),
        .element_bits  (element_bits),
        .norm_value    (norm_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit_index     (hit_index),
        .score         (score),
        .hit_valid     (hit_valid),
        .last          (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Half precision to signed Q2.16, round half away from zero, saturate
    function automatic longint to_fixed(input logic [15:0] h);
        int     e;
        longint mag;
        longint mant;
        e    = h[14:10];
        mant = longint'({1'b1, h[9:0]});
        if (e == 31)
            return (h[9:0] != 0) ? 0 : (h[15] ? -131072 : 131071);
        if (e == 0)
            mag = (longint'(h[9:0]) + 128) >>> 8;
        else if (e >= 9)
            mag = mant <<< (e - 9);
        else
            mag = (mant + (longint'(1) <<< (8 - e))) >>> (9 - e);
        if (h[15])
            return (mag > 131072) ? -131072 : -mag;
        return (mag > 131071) ? 131071 : mag;
    endfunction

    // Score every usable record and queue the ranked hit list
    task automatic rank_search(input logic [31:0] qn);
        int           dim;
        int           nrec;
        int           k;
        int           n;
        int           pos;
        int           key;
        longint       acc;
        longint       sc;
        logic [63:0]  mag;
        logic [63:0]  den;
        logic [127:0] quo;
        int           best_i [64];
        longint       best_s [64];
        hit_t         h;
        dim  = (m_dim > 1024) ? 1024 : m_dim;
        nrec = (m_nrec > 1024) ? 1024 : m_nrec;
        k    = (m_topk == 0) ? 1 : ((m_topk > 64) ? 64 : m_topk);
        n    = 0;
        if (qn != 0 && dim != 0) begin
            for (int r = 0; r < nrec; r++)
            begin
                if (norm_mem[r] == 0)
                    continue;
                acc = 0;
                for (int d = 0; d < dim; d++)
                begin
                    key = r * 1024 + d;
                    acc += to_fixed(query_mem[d])
                         * to_fixed(vec_mem.exists(key) ? vec_mem[key] : 16'h0);
                end
                mag = (acc < 0) ? 64'(-acc) : 64'(acc);
                den = 64'(qn) * 64'(norm_mem[r]);
                quo = ({64'h0, mag} << 46) / {64'h0, den};
                if (quo > 128'h4000_0000)
                    quo = 128'h4000_0000;
                sc = (acc < 0) ? -longint'(quo[31:0]) : longint'(quo[31:0]);
                if (n < k)
                    n++;
                else if (!(sc > best_s[k-1]))
                    continue;
                pos = n - 1;
                while (pos > 0 && sc > best_s[pos-1])
                begin
                    best_s[pos] = best_s[pos-1];
                    best_i[pos] = best_i[pos-1];
                    pos--;
                end
                best_s[pos] = sc;
                best_i[pos] = r;
            end
        end
        if (n == 0) begin
            h = '{10'd0, 32'sd0, 1'b0, 1'b1};
            hits_due.push_back(h);
        end
        for (int j = 0; j < n; j++)
        begin
            h = '{10'(best_i[j]), 32'(best_s[j]), 1'b1, (j == n - 1)};
            hits_due.push_back(h);
        end
    endtask

    task automatic apply_op(input op_item_t it);
        case (it.op)
            OP_REC_ELEM:   vec_mem[int'(it.ri) * 1024 + int'(it.ei)] = it.bits;
            OP_REC_NORM:   norm_mem[it.ri] = it.norm;
            OP_QUERY_ELEM: query_mem[it.ei] = it.bits;
            default:       rank_search(it.norm);
        endcase
    endtask

    // Driver: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid      <= 1'b0;
            opcode        <= OP_REC_ELEM;
            record_index  <= '0;
            element_index <= '0;
            element_bits  <= '0;
            norm_value    <= '0;
            burst_left    = 1;
            gap_left      = 0;
        end
        else begin
            if (in_valid && in_ready)
                apply_op(cur);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (ops_to_send.size() > 0) begin
                    cur = ops_to_send.pop_front();
                    opcode        <= cur.op;
                    record_index  <= cur.ri;
                    element_index <= cur.ei;
                    element_bits  <= cur.bits;
                    norm_value    <= cur.norm;
                    in_valid      <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare hits, stall on a changing duty pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_cnt = 0;
            ready_pct = 100;
        end
        else begin
            if (out_valid && out_ready) begin
                if (hits_due.size() == 0)
                    report_mismatch($sformatf("hit with none due, index %0d", hit_index));
                else begin
                    got = hits_due.pop_front();
                    if (hit_index !== got.idx)
                        report_mismatch($sformatf("hit_index %0d, want %0d",
                                                  hit_index, got.idx));
                    if (score !== got.scr)
                        report_mismatch($sformatf("score %0d, want %0d", score, got.scr));
                    if (hit_valid !== got.hv)
                        report_mismatch($sformatf("hit_valid %0b, want %0b",
                                                  hit_valid, got.hv));
                    if (last !== got.lst)
                        report_mismatch($sformatf("last %0b, want %0b", last, got.lst));
                end
            end
            if (stall_cnt == 0) begin
                stall_cnt = $urandom_range(16, 200);
                case ($urandom_range(0, 4))
                    0, 1:    ready_pct = 100;
                    2:       ready_pct = 70;
                    3:       ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            else
                stall_cnt--;
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_op(input cts_op_t op, input int ri, input int ei,
                           input logic [15:0] bits, input logic [31:0] norm);
        op_item_t it;
        it = '{op, 10'(ri), 10'(ei), bits, norm};
        ops_to_send.push_back(it);
    endtask

    function automatic logic [15:0] rand_elem(input bit tie);
        logic [15:0] specials [8] = '{16'h7C00, 16'hFC00, 16'h7E00, 16'h7BFF,
                                      16'h0001, 16'h83FF, 16'h0000, 16'h8000};
        logic [15:0] plain [4] = '{16'h3C00, 16'hBC00, 16'h3800, 16'h0000};
        int sel;
        sel = $urandom_range(0, 9);
        if (tie)
            return plain[$urandom_range(0, 3)];
        if (sel == 0)
            return 16'($urandom);
        if (sel == 1)
            return specials[$urandom_range(0, 7)];
        return {1'($urandom), 5'($urandom_range(10, 16)), 10'($urandom)};
    endfunction

    function automatic logic [31:0] rand_norm();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'($urandom_range(1, 255));
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom;
            default: return 32'($urandom_range(32'h0040_0000, 32'h0800_0000));
        endcase
    endfunction

    task automatic wait_idle();
        while (ops_to_send.size() != 0 || in_valid || hits_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 11'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_DIM_IN_USE)
            m_dim = 11'(val);
        else if (idx == CFG_RECORD_COUNT)
            m_nrec = 11'(val);
        else if (idx == CFG_TOP_K)
            m_topk = 7'(val);
    endtask

    // Set up a phase: registers, then every record and query element in use
    task automatic setup_phase(input int dim, input int nrec, input int k,
                               input bit tie);
        int ed;
        int er;
        wait_idle();
        set_reg(CFG_DIM_IN_USE, dim);
        set_reg(CFG_RECORD_COUNT, nrec);
        set_reg(CFG_TOP_K, k);
        ed = (dim > 1024) ? 1024 : dim;
        er = (nrec > 1024) ? 1024 : nrec;
        for (int r = 0; r < er; r++)
        begin
            push_op(OP_REC_NORM, r, $urandom_range(0, 1023), 16'($urandom), rand_norm());
            for (int d = 0; d < ed; d++)
                push_op(OP_REC_ELEM, r, d, rand_elem(tie), $urandom);
        end
        for (int d = 0; d < ed; d++)
            push_op(OP_QUERY_ELEM, $urandom_range(0, 1023), d, rand_elem(tie), $urandom);
    endtask

    // Random mix of overwrites and searches, mostly within the defined area, then a closing search
    task automatic random_items(input int count, input bit tie);
        int ed;
        int er;
        ed = (m_dim > 1024) ? 1024 : m_dim;
        er = (m_nrec > 1024) ? 1024 : m_nrec;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    push_op(OP_REC_ELEM,
                            (er > 0 && $urandom_range(0, 1)) ? $urandom_range(0, er - 1)
                                                             : $urandom_range(0, 1023),
                            (ed > 0) ? $urandom_range(0, ed - 1) : $urandom_range(0, 1023),
                            rand_elem(tie), $urandom);
                3, 4:
                    push_op(OP_REC_NORM,
                            (er > 0 && $urandom_range(0, 3)) ? $urandom_range(0, er - 1)
                                                             : $urandom_range(0, 1023),
                            $urandom_range(0, 1023), 16'($urandom), rand_norm());
                5, 6:
                    push_op(OP_QUERY_ELEM, $urandom_range(0, 1023),
                            (ed > 0 && $urandom_range(0, 3)) ? $urandom_range(0, ed - 1)
                                                             : $urandom_range(0, 1023),
                            rand_elem(tie), $urandom);
                default:
                    push_op(OP_SEARCH, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            16'($urandom), rand_norm());
            endcase
        end
        push_op(OP_SEARCH, 0, 0, 16'h0, 32'h0100_0000);
    endtask

    initial
    begin
        int k;
        errors      = 0;
        idle_cycles = 0;
        m_dim       = 11'd1024;
        m_nrec      = 11'd0;
        m_topk      = 7'd1;
        cfg_write   = 1'b0;
        cfg_index   = CFG_DIM_IN_USE;
        cfg_data    = '0;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty store after reset, then special values
        push_op(OP_SEARCH, 0, 0, 16'h0, 32'h0100_0000);
        wait_idle();
        set_reg(CFG_UNUSED, 11'h7FF);
        set_reg(CFG_DIM_IN_USE, 4);
        set_reg(CFG_RECORD_COUNT, 3);
        set_reg(CFG_TOP_K, 2);
        push_op(OP_REC_ELEM, 0, 0, 16'h7C00, 0);
        push_op(OP_REC_ELEM, 0, 1, 16'hFC00, 0);
        push_op(OP_REC_ELEM, 0, 2, 16'h7E00, 0);
        push_op(OP_REC_ELEM, 0, 3, 16'h0001, 0);
        push_op(OP_REC_ELEM, 1, 0, 16'h7BFF, 0);
        push_op(OP_REC_ELEM, 1, 1, 16'h8400, 0);
        push_op(OP_REC_ELEM, 1, 2, 16'h0200, 0);
        push_op(OP_REC_ELEM, 1, 3, 16'h3C00, 0);
        push_op(OP_REC_NORM, 0, 0, 0, 32'h0100_0000);
        push_op(OP_REC_NORM, 1, 0, 0, 32'hFFFF_FFFF);
        push_op(OP_REC_NORM, 2, 0, 0, 32'h0);
        push_op(OP_REC_NORM, 1023, 1023, 16'hFFFF, 32'hFFFF_FFFF);
        push_op(OP_REC_ELEM, 1023, 1023, 16'hFFFF, 32'hFFFF_FFFF);
        push_op(OP_QUERY_ELEM, 0, 0, 16'h3C00, 0);
        push_op(OP_QUERY_ELEM, 0, 1, 16'hBC00, 0);
        push_op(OP_QUERY_ELEM, 0, 2, 16'h03FF, 0);
        push_op(OP_QUERY_ELEM, 0, 3, 16'h7C00, 0);
        push_op(OP_QUERY_ELEM, 0, 1023, 16'h8001, 0);
        push_op(OP_SEARCH, 0, 0, 0, 32'h0);
        push_op(OP_SEARCH, 0, 0, 0, 32'h0000_0001);
        push_op(OP_SEARCH, 0, 0, 0, 32'hFFFF_FFFF);
        push_op(OP_SEARCH, 1023, 1023, 16'hFFFF, 32'h0100_0000);
        wait_idle();
        set_reg(CFG_DIM_IN_USE, 0);
        push_op(OP_SEARCH, 0, 0, 0, 32'h0100_0000);

        // register extremes: clamps that touch no stored entry
        wait_idle();
        set_reg(CFG_DIM_IN_USE, 2047);
        set_reg(CFG_RECORD_COUNT, 0);
        set_reg(CFG_TOP_K, 127);
        push_op(OP_SEARCH, 0, 0, 16'h0, 32'h0100_0000);
        wait_idle();
        set_reg(CFG_DIM_IN_USE, 0);
        set_reg(CFG_RECORD_COUNT, 2047);
        set_reg(CFG_TOP_K, 0);
        push_op(OP_SEARCH, 0, 0, 16'h0, 32'h0100_0000);
        setup_phase(1, 70, 64, 1'b1);
        random_items(10, 1'b1);
        setup_phase(3, 12, 100, 1'b1);
        random_items(8, 1'b1);

        // random phases, small sizes
        for (int p = 0; p < 3; p++)
        begin
            case ($urandom_range(0, 5))
                0:       k = 0;
                1:       k = 1;
                2:       k = 64;
                3:       k = 127;
                default: k = $urandom_range(2, 8);
            endcase
            setup_phase(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                   : $urandom_range(1, 8),
                        $urandom_range(0, 8), k, ($urandom_range(0, 3) == 0));
            random_items(10, ($urandom_range(0, 3) == 0));
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (hits_due.size() != 0)
            report_mismatch($sformatf("%0d hits never arrived", hits_due.size()));
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/cts_pkg.sv
rtl/core/cts_divider.sv
rtl/core/cts_best_list.sv
rtl/core/cosine_top_k_search_core.sv
tb/sv/tb.sv
